// ----- hw/rtl/mvm_pkg.sv -----
// shared types and constants of the matrix-vector multiply block
package mvm_pkg;

    localparam int MAX_ROWS      = 64;
    localparam int MAX_COLS      = 64;
    localparam int ELEMENT_WIDTH = 16;
    localparam int FRAC_BITS     = 12;
    localparam int ACC_WIDTH     = 40;
    localparam int PROD_WIDTH    = 2 * ELEMENT_WIDTH;
    localparam int ROW_W         = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W         = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int SIZE_W        = 7;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [SIZE_W-1:0]            ROWS_RESET  = 7'd64;
    localparam logic [SIZE_W-1:0]            COLS_RESET  = 7'd64;
    localparam logic signed [ELEMENT_WIDTH-1:0] SCALE_RESET = 16'sd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_IN_USE  = 2'd0,
        REG_COLS_IN_USE  = 2'd1,
        REG_SCALE_FACTOR = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [ELEMENT_WIDTH-1:0] matrix_element;
        logic signed [ELEMENT_WIDTH-1:0] vector_element;
    } in_item_t;

    typedef struct packed {
        logic [5:0]                  row_index;
        logic signed [ACC_WIDTH-1:0] result_value;
        logic                        last_row;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FACTOR,
        ST_PRODUCT,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic calc_factor;
        logic calc_product;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic commit_stall;
    } status_t;

endpackage

// ----- hw/rtl/mvm_ctrl.sv -----
// sequencing state machine of the matrix-vector multiply block
module mvm_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mvm_pkg::status_t status,
    output mvm_pkg::cmd_t    cmd,
    output mvm_pkg::state_t  state
);
    import mvm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_FACTOR;
            end
            ST_FACTOR:  state_next = ST_PRODUCT;
            ST_PRODUCT: state_next = ST_COMMIT;
            ST_COMMIT: begin
                if (!status.commit_stall) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            ST_FACTOR:  cmd.calc_factor  = 1'b1;
            ST_PRODUCT: cmd.calc_product = 1'b1;
            ST_COMMIT:  cmd.commit       = !status.commit_stall;
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign state = state_reg;

endmodule

// ----- hw/rtl/mvm_dp.sv -----
// datapath: config registers, counters, multipliers, accumulator memory, result register
module mvm_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_write_en,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mvm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  mvm_pkg::in_item_t                    s_data,
    output mvm_pkg::out_item_t                   m_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    input  mvm_pkg::cmd_t                        cmd,
    output mvm_pkg::status_t                     status
);
    import mvm_pkg::*;

    localparam int SAT_HI_W = PROD_WIDTH - FRAC_BITS - ELEMENT_WIDTH + 1;

    logic [SIZE_W-1:0]                  rows_cfg_reg;
    logic [SIZE_W-1:0]                  cols_cfg_reg;
    logic signed [ELEMENT_WIDTH-1:0]    scale_reg;
    logic [ROW_W-1:0]                   row_cnt_reg;
    logic [COL_W-1:0]                   col_cnt_reg;
    logic signed [ELEMENT_WIDTH-1:0]    factor_reg;
    logic signed [ELEMENT_WIDTH-1:0]    elem_reg;
    logic signed [ELEMENT_WIDTH-1:0]    vec_reg;
    logic signed [PROD_WIDTH-1:0]       prod_reg;
    logic signed [ACC_WIDTH-1:0]        rd_reg;
    out_item_t                          out_reg;
    logic                               out_valid_reg;

    logic signed [ACC_WIDTH-1:0]        acc_mem [MAX_ROWS];

    logic [SIZE_W-1:0]                  rows_eff;
    logic [SIZE_W-1:0]                  cols_eff;
    logic                               last_row;
    logic                               first_col;
    logic                               last_col;
    logic signed [PROD_WIDTH-1:0]       fprod;
    logic [SAT_HI_W-1:0]                fprod_hi;
    logic signed [ELEMENT_WIDTH-1:0]    factor_sat;
    logic signed [ACC_WIDTH:0]          sum_wide;
    logic signed [ACC_WIDTH-1:0]        acc_new;
    logic signed [ACC_WIDTH-1:0]        prod_ext;

    // zero acts as one, anything above the maximum acts as the maximum
    always_comb begin
        rows_eff = rows_cfg_reg;
        if (rows_cfg_reg == '0) rows_eff = SIZE_W'(1);
        else if (rows_cfg_reg > SIZE_W'(MAX_ROWS)) rows_eff = SIZE_W'(MAX_ROWS);
        cols_eff = cols_cfg_reg;
        if (cols_cfg_reg == '0) cols_eff = SIZE_W'(1);
        else if (cols_cfg_reg > SIZE_W'(MAX_COLS)) cols_eff = SIZE_W'(MAX_COLS);
    end

    assign last_row  = SIZE_W'(row_cnt_reg) >= (rows_eff - SIZE_W'(1));
    assign last_col  = SIZE_W'(col_cnt_reg) >= (cols_eff - SIZE_W'(1));
    assign first_col = (col_cnt_reg == '0);

    // column factor: floor shift of the q8.24 product, saturated to q4.12
    assign fprod    = vec_reg * scale_reg;
    assign fprod_hi = fprod[PROD_WIDTH-1:FRAC_BITS+ELEMENT_WIDTH-1];
    always_comb begin
        if (fprod_hi == '0 || &fprod_hi) begin
            factor_sat = fprod[FRAC_BITS+ELEMENT_WIDTH-1:FRAC_BITS];
        end else if (fprod[PROD_WIDTH-1]) begin
            factor_sat = {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};
        end else begin
            factor_sat = {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};
        end
    end

    // accumulate with saturation to the accumulator range
    assign prod_ext = ACC_WIDTH'(prod_reg);
    assign sum_wide = (ACC_WIDTH+1)'(rd_reg) + (ACC_WIDTH+1)'(prod_ext);
    always_comb begin
        if (first_col) begin
            acc_new = prod_ext;
        end else if (sum_wide[ACC_WIDTH] != sum_wide[ACC_WIDTH-1]) begin
            acc_new = sum_wide[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                          : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end else begin
            acc_new = sum_wide[ACC_WIDTH-1:0];
        end
    end

    assign status.commit_stall = last_col && out_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg  <= ROWS_RESET;
            cols_cfg_reg  <= COLS_RESET;
            scale_reg     <= SCALE_RESET;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            factor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_write_en) begin
                case (cfg_index)
                    REG_ROWS_IN_USE:  rows_cfg_reg <= cfg_data[SIZE_W-1:0];
                    REG_COLS_IN_USE:  cols_cfg_reg <= cfg_data[SIZE_W-1:0];
                    REG_SCALE_FACTOR: scale_reg    <= cfg_data[ELEMENT_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (cmd.calc_factor && row_cnt_reg == '0) begin
                factor_reg <= factor_sat;
            end
            if (cmd.commit && last_col) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.commit) begin
                if (last_row) begin
                    row_cnt_reg <= '0;
                    col_cnt_reg <= last_col ? '0 : col_cnt_reg + COL_W'(1);
                end else begin
                    row_cnt_reg <= row_cnt_reg + ROW_W'(1);
                end
            end
        end
    end

    // payload registers and accumulator memory
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            elem_reg <= s_data.matrix_element;
            vec_reg  <= s_data.vector_element;
            rd_reg   <= acc_mem[row_cnt_reg];
        end
        if (cmd.calc_product) begin
            prod_reg <= elem_reg * factor_reg;
        end
        if (cmd.commit) begin
            acc_mem[row_cnt_reg] <= acc_new;
            if (last_col) begin
                out_reg.row_index    <= 6'(row_cnt_reg);
                out_reg.result_value <= acc_new;
                out_reg.last_row     <= last_row;
            end
        end
    end

    assign m_data  = out_reg;
    assign m_valid = out_valid_reg;

endmodule

// ----- hw/rtl/matrix_vector_multiply_top.sv -----
// a request is accepted in the idle state and its result is registered by the commit step
// a new request is taken only once the last one is through its four steps (accept and memory
//   read, column factor multiply, element multiply, accumulate and write back)
// a commit in the last column waits while the result register is still full and not taken
// reset: synchronous, active low; clears counters, column factor, result valid and loads
//   the size and scale registers with their defaults; accumulator memory is not cleared
module matrix_vector_multiply_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_write_en,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mvm_pkg::CFG_DATA_W-1:0]  cfg_data,
    // request channel: one matrix element and its column's vector element
    input  logic                            s_valid,
    output logic                            s_ready,
    input  mvm_pkg::in_item_t               s_data,
    // result channel: one finished row in the last column
    output logic                            m_valid,
    input  logic                            m_ready,
    output mvm_pkg::out_item_t              m_data
);
    import mvm_pkg::*;

    cmd_t    cmd;
    status_t status;
    state_t  state;

    // controller steps one request through the shared datapath
    mvm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd),
        .state   (state)
    );

    // datapath holds config, counters, multipliers and row accumulators
    mvm_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_data       (s_data),
        .m_data       (m_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .cmd          (cmd),
        .status       (status)
    );

    // a request in flight blocks the next one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while previous one still in flight");

    // a new result only appears out of the commit step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state == ST_COMMIT))
        else $error("result valid raised outside commit");

    // reset leaves no result pending and the block ready
    assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("reset did not clear result or ready");

endmodule

// ----- tb/sv/mvm_check_pkg.sv -----
// result predictor and scoreboard for the matrix-vector multiply block
package mvm_check_pkg;

    import mvm_pkg::*;

    class mvm_scoreboard;
        logic [SIZE_W-1:0] rows_reg;
        logic [SIZE_W-1:0] cols_reg;
        shortint           alpha;
        longint            row_sums [MAX_ROWS];
        int unsigned       row_pos;
        int unsigned       col_pos;
        shortint           col_factor;
        out_item_t         expected_rows [$];
        int                mismatches;

        function new();
            rows_reg   = ROWS_RESET;
            cols_reg   = COLS_RESET;
            alpha      = SCALE_RESET;
            row_pos    = 0;
            col_pos    = 0;
            col_factor = 0;
            mismatches = 0;
            foreach (row_sums[i]) row_sums[i] = 0;
        endfunction

        // zero acts as one, anything past the maximum acts as the maximum
        function int unsigned effective_size(logic [SIZE_W-1:0] v, int unsigned limit);
            if (v == 0)
                return 1;
            if (v > limit)
                return limit;
            return 32'(v);
        endfunction

        function longint clip(longint v, int unsigned w);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        function void note_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_ROWS_IN_USE:  rows_reg = value[SIZE_W-1:0];
                REG_COLS_IN_USE:  cols_reg = value[SIZE_W-1:0];
                REG_SCALE_FACTOR: alpha = value;
                default: ;
            endcase
        endfunction

        function void note_request(in_item_t item);
            int unsigned rows;
            int unsigned cols;
            int unsigned r;
            bit          last_r;
            bit          first_c;
            bit          last_c;
            longint      a;
            longint      x;
            longint      prod;
            longint      sum;
            out_item_t   res;
            rows    = effective_size(rows_reg, MAX_ROWS);
            cols    = effective_size(cols_reg, MAX_COLS);
            a       = longint'(shortint'(item.matrix_element));
            x       = longint'(shortint'(item.vector_element));
            r       = row_pos;
            last_r  = (r >= rows - 1);
            first_c = (col_pos == 0);
            last_c  = (col_pos >= cols - 1);
            // column factor is formed on row zero only, floor shift then saturate
            if (r == 0)
                col_factor = shortint'(clip((x * longint'(alpha)) >>> FRAC_BITS,
                                            ELEMENT_WIDTH));
            prod = a * longint'(col_factor);
            sum  = first_c ? prod : clip(row_sums[r] + prod, ACC_WIDTH);
            row_sums[r] = sum;
            if (last_c) begin
                res.row_index    = r[5:0];
                res.result_value = sum[ACC_WIDTH-1:0];
                res.last_row     = last_r;
                expected_rows.push_back(res);
            end
            if (last_r) begin
                row_pos = 0;
                col_pos = last_c ? 0 : col_pos + 1;
            end else begin
                row_pos = r + 1;
            end
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (expected_rows.size() == 0) begin
                report_mismatch($sformatf("unexpected result for row %0d", got.row_index));
                return;
            end
            want = expected_rows.pop_front();
            if (got.row_index !== want.row_index)
                report_mismatch($sformatf("row_index %0d, want %0d",
                                          got.row_index, want.row_index));
            if (got.result_value !== want.result_value)
                report_mismatch($sformatf("row %0d result_value %h, want %h", want.row_index,
                                          got.result_value, want.result_value));
            if (got.last_row !== want.last_row)
                report_mismatch($sformatf("row %0d last_row %b, want %b", want.row_index,
                                          got.last_row, want.last_row));
        endtask

        function int pending();
            return expected_rows.size();
        endfunction

        task flag_leftovers();
            if (expected_rows.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", expected_rows.size()));
        endtask
    endclass

endpackage

// ----- tb/sv/tb_matrix_vector_multiply_top.sv -----
// testbench for the column-major matrix-vector multiply block
module tb_matrix_vector_multiply_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mvm_pkg::*;
    import mvm_check_pkg::*;

    // register index past the end of the map, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
    // cycles to let the pipeline empty once no result is outstanding
    localparam int LATENCY_SLACK = 8;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_GUARD   = 20000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;

    mvm_scoreboard sb = new();

    // both sides run without idling while this is set
    bit no_idle;
    // asks the result side for one long hold-off
    bit hold_pending;

    matrix_vector_multiply_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // hard stop in case the block hangs
    initial begin
        #(5_000_000);
        $display("** matrix_vector_multiply_top: FAILED **");
        $finish;
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 7);
            end
        end
    end

    // every accepted result is checked against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    function automatic logic [ELEMENT_WIDTH-1:0] pick_element();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return ELEMENT_WIDTH'($urandom);
        endcase
    endfunction

    function automatic in_item_t make_request(logic [ELEMENT_WIDTH-1:0] a,
                                              logic [ELEMENT_WIDTH-1:0] x);
        in_item_t item;
        item.matrix_element = a;
        item.vector_element = x;
        return item;
    endfunction

    // offer one request, with an occasional gap first; valid stays high after
    // acceptance so back-to-back requests need no dead cycle
    task automatic send_request(input in_item_t item);
        int gap;
        gap = (!no_idle && $urandom_range(0, 99) < 7) ? $urandom_range(1, 6) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(item);
    endtask

    task automatic feed_random(input int unsigned n);
        repeat (n) send_request(make_request(pick_element(), pick_element()));
    endtask

    // drop valid, wait for every predicted result, then let the pipeline empty;
    // after this the block is idle and registers may be written
    task automatic settle();
        int guard;
        guard = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() > 0 && guard < DRAIN_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        repeat (LATENCY_SLACK) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(negedge aclk);
        cfg_write_en <= 1'b0;
        sb.note_write(idx, value);
    endtask

    initial begin
        int unsigned           sent;
        int unsigned           rows_raw;
        int unsigned           cols_raw;
        int unsigned           n_items;
        int                    matrix_no;
        logic [CFG_DATA_W-1:0] word;

        aresetn      = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = REG_ROWS_IN_USE;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        no_idle      = 1'b0;
        hold_pending = 1'b0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset defaults: 64 rows, 64 columns, alpha of one; run the first
        // column, then cut the width to one so the second column finishes
        feed_random(64);
        settle();
        write_register(REG_COLS_IN_USE, 16'd1);
        feed_random(64);
        settle();

        // zero sizes act as a 1x1 matrix, so every request gives a result;
        // alpha at both extremes drives the column factor into saturation
        write_register(REG_ROWS_IN_USE, 16'd0);
        write_register(REG_COLS_IN_USE, 16'd0);
        for (int k = 0; k < 2; k++) begin
            write_register(REG_SCALE_FACTOR, (k == 0) ? 16'h8000 : 16'h7FFF);
            send_request(make_request(16'h7FFF, 16'h7FFF));
            send_request(make_request(16'h8000, 16'h8000));
            send_request(make_request(16'h8000, 16'h7FFF));
            send_request(make_request(16'hFFFF, 16'h0001));
            settle();
        end

        // 3x2 with alpha of one; vector element off row zero must be ignored,
        // and a write past the register map must change nothing
        write_register(REG_ROWS_IN_USE, 16'd3);
        write_register(REG_COLS_IN_USE, 16'd2);
        write_register(REG_SCALE_FACTOR, 16'd4096);
        write_register(REG_UNMAPPED, 16'h0005);
        feed_random(6);
        settle();

        // sizes shrunk mid-matrix: counters past the new last index wrap,
        // the row in flight is emitted as the last one
        write_register(REG_ROWS_IN_USE, 16'd4);
        write_register(REG_COLS_IN_USE, 16'd3);
        feed_random(6);
        settle();
        write_register(REG_ROWS_IN_USE, 16'd2);
        write_register(REG_COLS_IN_USE, 16'd2);
        feed_random(1);
        settle();

        // random matrices, each one started from an idle block
        sent = 0;
        matrix_no = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0: rows_raw = 0;
                1: rows_raw = MAX_ROWS;
                2: rows_raw = $urandom_range(MAX_ROWS + 1, 127);
                default: rows_raw = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 19))
                0: cols_raw = 0;
                1: cols_raw = MAX_COLS;
                2: cols_raw = $urandom_range(MAX_COLS + 1, 127);
                default: cols_raw = $urandom_range(1, 8);
            endcase
            // keep big matrices rare and short
            if (sb.effective_size(rows_raw[SIZE_W-1:0], MAX_ROWS)
                    * sb.effective_size(cols_raw[SIZE_W-1:0], MAX_COLS) > 256)
                cols_raw = $urandom_range(1, 4);
            // one tall single-column matrix while the result side holds off:
            // results pile up and the block has to stall its input
            if (matrix_no == 6) begin
                rows_raw = MAX_ROWS;
                cols_raw = 1;
            end
            no_idle = (matrix_no >= 15 && matrix_no < 25);

            word = CFG_DATA_W'($urandom);
            word[SIZE_W-1:0] = rows_raw[SIZE_W-1:0];
            write_register(REG_ROWS_IN_USE, word);
            word = CFG_DATA_W'($urandom);
            word[SIZE_W-1:0] = cols_raw[SIZE_W-1:0];
            write_register(REG_COLS_IN_USE, word);
            case ($urandom_range(0, 7))
                0: word = 16'h7FFF;
                1: word = 16'h8000;
                2: word = 16'd4096;
                default: word = CFG_DATA_W'($urandom);
            endcase
            write_register(REG_SCALE_FACTOR, word);

            if (matrix_no == 6)
                hold_pending = 1'b1;
            n_items = sb.effective_size(rows_raw[SIZE_W-1:0], MAX_ROWS)
                    * sb.effective_size(cols_raw[SIZE_W-1:0], MAX_COLS);
            feed_random(n_items);
            sent += n_items;
            settle();
            matrix_no++;
        end
        no_idle = 1'b0;

        // settle already waited out the pipeline; anything still predicted is lost
        sb.flag_leftovers();
        if (sb.mismatches == 0) begin
            $display("** matrix_vector_multiply_top: PASSED **");
        end else begin
            $display("** matrix_vector_multiply_top: FAILED **");
        end
        $finish;
    end

endmodule
